>>> rtl/acsr_pkg.sv
package acsr_pkg;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_MRU  = 2'd2;
  localparam logic [1:0] POL_LFU  = 2'd3;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_PUT    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_LOOK  = 3'd2;
  localparam logic [2:0] OP_TOUCH = 3'd3;
  localparam logic [2:0] OP_DOWN  = 3'd4;
  localparam logic [2:0] OP_UP    = 3'd5;
  localparam logic [2:0] OP_FIX   = 3'd6;

  typedef struct packed {
    logic [2:0] op;
  } dp_ctl_t;

  typedef struct packed {
    logic       hit;
    logic       full;
    logic [1:0] command;
    logic [1:0] policy;
    logic       down_stop;
    logic       up_stop;
  } dp_stat_t;

endpackage

>>> rtl/acsr_datapath.sv
module acsr_datapath
  import acsr_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_ctl_t     ctl,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic [1:0]  in_command,
  input  logic [30:0] in_address,
  input  logic [31:0] in_value,
  output logic        res_hit,
  output logic [31:0] res_read_value,
  output logic        res_evicted,
  output logic [30:0] res_evicted_address,
  output logic [31:0] res_evicted_value,
  output logic        res_evicted_dirty
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int LW = SW + 2;
  localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);
  localparam logic [SW-1:0] LAST = SW'(CAPACITY - 1);

  logic [30:0]   addr_r  [CAPACITY];
  logic [31:0]   val_r   [CAPACITY];
  logic          dirty_r [CAPACITY];
  logic [31:0]   cnt_r   [CAPACITY];
  logic [SW-1:0] ol_r    [CAPACITY];
  logic [SW-1:0] ol_nxt  [CAPACITY];
  logic [NW-1:0] fill_r;
  logic [1:0]    policy_r;
  logic [1:0]    cmd_r;
  logic [30:0]   iaddr_r;
  logic [31:0]   ival_r;
  logic [SW-1:0] h_r;
  logic [SW-1:0] vic_r;
  logic [SW-1:0] pos_r;
  logic [NW-1:0] sift_n_r;

  logic          hit;
  logic [SW-1:0] hidx;
  logic          full;
  logic [SW-1:0] tpos;
  logic [SW-1:0] vic;
  logic [LW-1:0] dl, dr, nx;
  logic [SW-1:0] dc;
  logic [31:0]   c_pos, c_l, c_r, c_c, c_p;
  logic [SW-1:0] up_p;
  logic          down_stop, up_stop;

  assign full = (fill_r == CAP_N);

  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((i < int'(fill_r)) && (addr_r[i] == iaddr_r)) begin
        hit  = 1'b1;
        hidx = SW'(i);
      end
    end
  end

  always_comb begin
    tpos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((i < int'(fill_r)) && (ol_r[i] == h_r)) begin
        tpos = SW'(i);
      end
    end
  end

  always_comb begin
    case (policy_r)
      POL_LRU: vic = ol_r[LAST];
      default: vic = ol_r[0];
    endcase
  end

  always_comb begin
    dl    = {1'b0, pos_r, 1'b1};
    dr    = dl + LW'(1);
    nx    = LW'(sift_n_r);
    c_pos = cnt_r[ol_r[pos_r]];
    c_l   = cnt_r[ol_r[dl[SW-1:0]]];
    c_r   = cnt_r[ol_r[dr[SW-1:0]]];
    if ((dr < nx) && (c_l > c_r)) begin
      dc  = dr[SW-1:0];
      c_c = c_r;
    end else begin
      dc  = dl[SW-1:0];
      c_c = c_l;
    end
    down_stop = !(dl < nx) || !(c_pos >= c_c);
    up_p      = (pos_r - SW'(1)) >> 1;
    c_p       = cnt_r[ol_r[up_p]];
    up_stop   = (pos_r == '0) || !(c_p > c_pos);
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) ol_nxt[i] = ol_r[i];
    case (ctl.op)
      OP_LOOK: begin
        if (!hit && (cmd_r == CMD_WRITE || cmd_r == CMD_PUT)) begin
          if (!full) begin
            if (policy_r == POL_LRU || policy_r == POL_MRU) begin
              for (int i = 1; i < CAPACITY; i++) begin
                if (i <= int'(fill_r)) ol_nxt[i] = ol_r[i-1];
              end
              ol_nxt[0] = fill_r[SW-1:0];
            end else begin
              ol_nxt[fill_r[SW-1:0]] = fill_r[SW-1:0];
            end
          end else begin
            case (policy_r)
              POL_FIFO: begin
                for (int i = 0; i < CAPACITY - 1; i++) ol_nxt[i] = ol_r[i+1];
                ol_nxt[LAST] = ol_r[0];
              end
              POL_LRU: begin
                for (int i = 1; i < CAPACITY; i++) ol_nxt[i] = ol_r[i-1];
                ol_nxt[0] = ol_r[LAST];
              end
              POL_LFU: ol_nxt[0] = ol_r[LAST];
              default: ;
            endcase
          end
        end
      end
      OP_TOUCH: begin
        if (policy_r == POL_LRU || policy_r == POL_MRU) begin
          for (int i = 1; i < CAPACITY; i++) begin
            if (i <= int'(tpos)) ol_nxt[i] = ol_r[i-1];
          end
          ol_nxt[0] = ol_r[tpos];
        end
      end
      OP_DOWN: begin
        if (!down_stop) begin
          ol_nxt[pos_r] = ol_r[dc];
          ol_nxt[dc]    = ol_r[pos_r];
        end
      end
      OP_UP: begin
        if (!up_stop) begin
          ol_nxt[pos_r] = ol_r[up_p];
          ol_nxt[up_p]  = ol_r[pos_r];
        end
      end
      OP_FIX: ol_nxt[LAST] = vic_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) ol_r[i] <= ol_nxt[i];
    case (ctl.op)
      OP_LOAD: begin
        cmd_r               <= in_command;
        iaddr_r             <= in_address;
        ival_r              <= in_value;
        res_hit             <= 1'b0;
        res_read_value      <= '0;
        res_evicted         <= 1'b0;
        res_evicted_address <= '0;
        res_evicted_value   <= '0;
        res_evicted_dirty   <= 1'b0;
      end
      OP_LOOK: begin
        if (cmd_r != CMD_UNUSED) begin
          if (hit) begin
            res_hit <= 1'b1;
            h_r     <= hidx;
            if (cmd_r == CMD_READ) res_read_value <= val_r[hidx];
            else val_r[hidx] <= ival_r;
            if (cmd_r == CMD_WRITE) dirty_r[hidx] <= 1'b1;
            if (cmd_r != CMD_PUT && cnt_r[hidx] != 32'hFFFF_FFFF) begin
              cnt_r[hidx] <= cnt_r[hidx] + 32'd1;
            end
          end else if (cmd_r != CMD_READ) begin
            if (!full) begin
              addr_r[fill_r[SW-1:0]]  <= iaddr_r;
              val_r[fill_r[SW-1:0]]   <= ival_r;
              dirty_r[fill_r[SW-1:0]] <= (cmd_r == CMD_WRITE);
              cnt_r[fill_r[SW-1:0]]   <= 32'd1;
              pos_r                   <= fill_r[SW-1:0];
            end else begin
              res_evicted         <= 1'b1;
              res_evicted_address <= addr_r[vic];
              res_evicted_value   <= val_r[vic];
              res_evicted_dirty   <= dirty_r[vic];
              addr_r[vic]         <= iaddr_r;
              val_r[vic]          <= ival_r;
              dirty_r[vic]        <= (cmd_r == CMD_WRITE);
              cnt_r[vic]          <= 32'd1;
              vic_r               <= vic;
              pos_r               <= '0;
              sift_n_r            <= CAP_N;
            end
          end
        end
      end
      OP_TOUCH: begin
        pos_r    <= tpos;
        sift_n_r <= fill_r;
      end
      OP_DOWN: if (!down_stop) pos_r <= dc;
      OP_UP:   if (!up_stop) pos_r <= up_p;
      OP_FIX:  pos_r <= LAST;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      policy_r <= POL_LRU;
    end else begin
      if (cfg_we) policy_r <= cfg_data;
      if (ctl.op == OP_LOOK && cmd_r != CMD_UNUSED && !hit && cmd_r != CMD_READ && !full) begin
        fill_r <= fill_r + NW'(1);
      end
    end
  end

  assign stat.hit       = hit;
  assign stat.full      = full;
  assign stat.command   = cmd_r;
  assign stat.policy    = policy_r;
  assign stat.down_stop = down_stop;
  assign stat.up_stop   = up_stop;

endmodule

>>> rtl/acsr_controller.sv
module acsr_controller
  import acsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output dp_ctl_t  ctl,
  input  dp_stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_TOUCH = 3'd2;
  localparam logic [2:0] S_DOWN  = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;
  localparam logic [2:0] S_UP    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       fix_r, fix_nxt;
  logic       lfu;

  assign lfu  = (stat.policy == POL_LFU);
  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    fix_nxt   = fix_r;
    ctl.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.op    = OP_LOOK;
        state_nxt = S_DONE;
        if (stat.command != CMD_UNUSED) begin
          if (stat.hit) begin
            if (stat.command != CMD_PUT) state_nxt = S_TOUCH;
          end else if (stat.command != CMD_READ && lfu) begin
            fix_nxt   = stat.full;
            state_nxt = stat.full ? S_DOWN : S_UP;
          end
        end
      end
      S_TOUCH: begin
        ctl.op    = OP_TOUCH;
        fix_nxt   = 1'b0;
        state_nxt = lfu ? S_DOWN : S_DONE;
      end
      S_DOWN: begin
        ctl.op = OP_DOWN;
        if (stat.down_stop) state_nxt = fix_r ? S_FIX : S_DONE;
      end
      S_FIX: begin
        ctl.op    = OP_FIX;
        state_nxt = S_UP;
      end
      S_UP: begin
        ctl.op = OP_UP;
        if (stat.up_stop) state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fix_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fix_r   <= fix_nxt;
    end
  end

endmodule

>>> rtl/assoc_cache_selectable_replacement_unit.sv
// The strobe comes in the DONE state, which follows LOOK for a miss, a put hit or an
//   unused command, and follows LOOK and TOUCH for a read or write hit (order update); under
//   LFU a hit also sifts down, a non-full insert sifts up, and a full insert sifts down,
//   fixes and sifts up (sift down, fix, sift up) before DONE.
// One word is handled at a time; busy is high until the strobe cycle ends.
// The result is shown for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) empties the cache and sets the policy to LRU.
module assoc_cache_selectable_replacement_unit
  import acsr_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [30:0] in_address,
  input  logic [31:0] in_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_read_value,
  output logic        out_evicted,
  output logic [30:0] out_evicted_address,
  output logic [31:0] out_evicted_value,
  output logic        out_evicted_dirty
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  acsr_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .ctl   (ctl),
    .stat  (stat)
  );

  acsr_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_command          (in_command),
    .in_address          (in_address),
    .in_value            (in_value),
    .res_hit             (out_hit),
    .res_read_value      (out_read_value),
    .res_evicted         (out_evicted),
    .res_evicted_address (out_evicted_address),
    .res_evicted_value   (out_evicted_value),
    .res_evicted_dirty   (out_evicted_dirty)
  );

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("strobe outside busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> !out_hit) else $error("eviction on a hit");

  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_value != 32'd0) |-> out_hit) else $error("read data on a miss");

endmodule
